// File: src/polygon_plane_clip_defines.svh
// Assertion macros used by the clipper RTL.
`ifndef POLYGON_PLANE_CLIP_DEFINES_SVH
`define POLYGON_PLANE_CLIP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppc assertion failed");

// Next-cycle implication, disabled during reset.
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppc assertion failed");

`endif

// File: src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the polygon plane clipper.
// ----------------------------------------------------------------------------
package ppc_pkg;

   localparam int COORD_W = 32;
   localparam int DIST_W  = 48;
   localparam int NUM_W   = 48;
   localparam int DEN_W   = 49;
   localparam int REM_W   = 50;
   localparam int T_W     = 32;
   localparam int STEP_W  = 5;
   localparam int CNT_W   = 7;
   localparam int IDX_W   = 2;

   localparam logic [IDX_W-1:0] CSR_NORMAL_X     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_NORMAL_Y     = 2'd1;
   localparam logic [IDX_W-1:0] CSR_NORMAL_Z     = 2'd2;
   localparam logic [IDX_W-1:0] CSR_PLANE_OFFSET = 2'd3;

   localparam logic OP_PRIME  = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   typedef enum logic [1:0] {
      KIND_CUR,
      KIND_INT,
      KIND_INT_CUR
   } kind_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL_X,
      F_MUL_Y,
      F_MUL_Z,
      F_SUM,
      F_CLASS
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_MUL,
      B_ADD,
      B_EMIT_INT,
      B_EMIT_CUR
   } back_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] offset;
   } cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic                      final_v;
      logic signed [COORD_W-1:0] prev_x;
      logic signed [COORD_W-1:0] prev_y;
      logic signed [COORD_W-1:0] prev_z;
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
      logic signed [COORD_W-1:0] cur_z;
      logic [NUM_W-1:0]          num;
      logic [DEN_W-1:0]          den;
   } edge_type;

endpackage

// File: src/ppc_fifo.sv
// ----------------------------------------------------------------------------
// ppc_fifo
// Two-entry edge queue between the classifier and the clip engine.
// ----------------------------------------------------------------------------
`include "polygon_plane_clip_defines.svh"

module ppc_fifo import ppc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  edge_type push_data,
   input  logic     pop,
   output edge_type pop_data,
   output logic     full,
   output logic     empty
);

   edge_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PPC_ASSERT_IMP(a_push_room, clock, reset, push, !full)
   `PPC_ASSERT_IMP(a_pop_data, clock, reset, pop, !empty)
   `PPC_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

// File: src/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// Takes items, computes the signed plane distance with one shared multiplier,
// classifies the edge and queues work for the clip engine.
// ----------------------------------------------------------------------------
module ppc_front import ppc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic signed [COORD_W-1:0] req_px,
   input  logic signed [COORD_W-1:0] req_py,
   input  logic signed [COORD_W-1:0] req_pz,
   input  logic [CNT_W-1:0]          req_vert_count,
   input  logic                      req_final_vertex,
   input  logic                      fifo_full,
   output logic                      push,
   output edge_type                  push_data
);

   localparam logic signed [63:0] DIST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] DIST_MIN = -64'sh0000_8000_0000_0000;

   front_state_type state_ff, state_in;

   logic                      op_ff, final_ff, short_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [DIST_W-1:0]  prev_d_ff;
   logic                      suppress_ff, suppress_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [63:0]        acc_ff, acc_in;
   logic signed [63:0]        prod_sh;
   logic signed [COORD_W-1:0] mul_a, mul_b;
   logic signed [DIST_W-1:0]  dcur;
   logic [NUM_W-1:0]          mag_prev, mag_cur;
   logic                      pin, cin, emit, accept, commit;

   assign accept  = req_valid && (state_ff == F_IDLE);
   assign prod_sh = prod_ff >>> FRAC_BITS;

   always_comb begin
      if (acc_ff > DIST_MAX) begin
         dcur = DIST_MAX[DIST_W-1:0];
      end else if (acc_ff < DIST_MIN) begin
         dcur = DIST_MIN[DIST_W-1:0];
      end else begin
         dcur = acc_ff[DIST_W-1:0];
      end
   end

   assign mag_prev = prev_d_ff[DIST_W-1] ? (~prev_d_ff + 1'b1) : prev_d_ff;
   assign mag_cur  = dcur[DIST_W-1] ? (~dcur + 1'b1) : dcur;
   assign pin      = prev_d_ff[DIST_W-1];
   assign cin      = dcur[DIST_W-1];
   assign emit     = (op_ff == OP_VERTEX) && !suppress_ff && (pin || cin);

   always_comb begin
      push_data.kind    = (pin && cin) ? KIND_CUR : (pin ? KIND_INT : KIND_INT_CUR);
      push_data.final_v = final_ff;
      push_data.prev_x  = px_ff;
      push_data.prev_y  = py_ff;
      push_data.prev_z  = pz_ff;
      push_data.cur_x   = cx_ff;
      push_data.cur_y   = cy_ff;
      push_data.cur_z   = cz_ff;
      push_data.num     = mag_prev;
      push_data.den     = {1'b0, mag_prev} + {1'b0, mag_cur};
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      push        = 1'b0;
      commit      = 1'b0;
      suppress_in = suppress_ff;
      mul_a       = cfg.nx;
      mul_b       = cx_ff;
      acc_in      = acc_ff;
      case (state_ff)
         F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = F_MUL_X;
            end
         end
         F_MUL_X: begin
            state_in = F_MUL_Y;
         end
         F_MUL_Y: begin
            mul_a    = cfg.ny;
            mul_b    = cy_ff;
            acc_in   = 64'(cfg.offset) + prod_sh;
            state_in = F_MUL_Z;
         end
         F_MUL_Z: begin
            mul_a    = cfg.nz;
            mul_b    = cz_ff;
            acc_in   = acc_ff + prod_sh;
            state_in = F_SUM;
         end
         F_SUM: begin
            acc_in   = acc_ff + prod_sh;
            state_in = F_CLASS;
         end
         F_CLASS: begin
            if (!(emit && fifo_full)) begin
               push     = emit;
               commit   = 1'b1;
               state_in = F_IDLE;
               if (op_ff == OP_PRIME) begin
                  suppress_in = short_ff;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         suppress_ff <= 1'b0;
         px_ff       <= '0;
         py_ff       <= '0;
         pz_ff       <= '0;
         prev_d_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         suppress_ff <= suppress_in;
         if (commit) begin
            px_ff     <= cx_ff;
            py_ff     <= cy_ff;
            pz_ff     <= cz_ff;
            prev_d_ff <= dcur;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (accept) begin
         op_ff    <= req_op;
         final_ff <= req_final_vertex;
         short_ff <= (req_vert_count < CNT_W'(2));
         cx_ff    <= req_px;
         cy_ff    <= req_py;
         cz_ff    <= req_pz;
      end
   end

endmodule

// File: src/ppc_back.sv
// ----------------------------------------------------------------------------
// ppc_back
// Clip engine: restoring divide for the edge parameter, per-axis
// interpolation with saturation, and the registered result stage.
// ----------------------------------------------------------------------------
module ppc_back import ppc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fifo_empty,
   input  edge_type                  fifo_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_qx,
   output logic signed [COORD_W-1:0] rsp_qy,
   output logic signed [COORD_W-1:0] rsp_qz,
   output logic                      rsp_run_last,
   output logic                      rsp_poly_done
);

   back_state_type state_ff, state_in;

   edge_type                  ed_ff, ed_in;
   logic [REM_W-1:0]          rem_ff, rem_in, rem_sh;
   logic [T_W-1:0]            t_ff, t_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [1:0]                k_ff, k_in;
   logic [48:0]               phi_ff, phi_in, plo_ff, plo_in;
   logic                      neg_ff, neg_in;
   logic signed [COORD_W-1:0] q_ff [3];
   logic signed [COORD_W-1:0] q_in [3];
   logic signed [COORD_W-1:0] sel_a, sel_b;
   logic signed [32:0]        delta;
   logic [32:0]               mag_d;
   logic [49:0]               s_sum;
   logic [33:0]               s_off;
   logic signed [34:0]        r_full;
   logic signed [COORD_W-1:0] r_sat;

   logic                      out_v_ff, out_v_in;
   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic                      orl_ff, orl_in, opd_ff, opd_in;
   logic                      slot_free, load;

   assign slot_free = !out_v_ff || !rsp_stall;

   always_comb begin
      case (k_ff)
         2'd0:    begin sel_a = ed_ff.prev_x; sel_b = ed_ff.cur_x; end
         2'd1:    begin sel_a = ed_ff.prev_y; sel_b = ed_ff.cur_y; end
         default: begin sel_a = ed_ff.prev_z; sel_b = ed_ff.cur_z; end
      endcase
   end

   assign delta  = 33'(sel_b) - 33'(sel_a);
   assign mag_d  = delta[32] ? (~delta + 1'b1) : delta;
   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};
   assign s_sum  = {1'b0, phi_ff} + {17'd0, plo_ff[48:16]};
   assign s_off  = s_sum[49:16];
   assign r_full = neg_ff ? (35'(sel_a) - $signed({1'b0, s_off}))
                          : (35'(sel_a) + $signed({1'b0, s_off}));

   always_comb begin
      if (r_full > 35'sh0_7FFF_FFFF) begin
         r_sat = 32'sh7FFF_FFFF;
      end else if (r_full < -35'sh0_8000_0000) begin
         r_sat = -32'sh8000_0000;
      end else begin
         r_sat = r_full[COORD_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load     = 1'b0;
      ed_in    = ed_ff;
      rem_in   = rem_ff;
      t_in     = t_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      phi_in   = phi_ff;
      plo_in   = plo_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      orl_in   = orl_ff;
      opd_in   = opd_ff;
      case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               pop     = 1'b1;
               ed_in   = fifo_data;
               rem_in  = {2'b00, fifo_data.num};
               t_in    = '0;
               step_in = '0;
               k_in    = 2'd0;
               if (fifo_data.kind == KIND_CUR) begin
                  state_in = B_EMIT_CUR;
               end else if ({1'b0, fifo_data.num} == fifo_data.den) begin
                  // current vertex lies on the plane: intersection is exact
                  q_in[0]  = fifo_data.cur_x;
                  q_in[1]  = fifo_data.cur_y;
                  q_in[2]  = fifo_data.cur_z;
                  state_in = B_EMIT_INT;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            if (rem_sh >= {1'b0, ed_ff.den}) begin
               rem_in = rem_sh - {1'b0, ed_ff.den};
               t_in   = {t_ff[T_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               t_in   = {t_ff[T_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(T_W - 1)) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            phi_in   = 49'(mag_d) * 49'(t_ff[31:16]);
            plo_in   = 49'(mag_d) * 49'(t_ff[15:0]);
            neg_in   = delta[32];
            state_in = B_ADD;
         end
         B_ADD: begin
            q_in[k_ff] = r_sat;
            if (k_ff == 2'd2) begin
               state_in = B_EMIT_INT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = B_MUL;
            end
         end
         B_EMIT_INT: begin
            if (slot_free) begin
               load   = 1'b1;
               ox_in  = q_ff[0];
               oy_in  = q_ff[1];
               oz_in  = q_ff[2];
               orl_in = (ed_ff.kind == KIND_INT);
               opd_in = (ed_ff.kind == KIND_INT) && ed_ff.final_v;
               state_in = (ed_ff.kind == KIND_INT) ? B_IDLE : B_EMIT_CUR;
            end
         end
         B_EMIT_CUR: begin
            if (slot_free) begin
               load     = 1'b1;
               ox_in    = ed_ff.cur_x;
               oy_in    = ed_ff.cur_y;
               oz_in    = ed_ff.cur_z;
               orl_in   = 1'b1;
               opd_in   = ed_ff.final_v;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (load) begin
         out_v_in = 1'b1;
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ed_ff   <= ed_in;
      rem_ff  <= rem_in;
      t_ff    <= t_in;
      step_ff <= step_in;
      k_ff    <= k_in;
      phi_ff  <= phi_in;
      plo_ff  <= plo_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      oz_ff   <= oz_in;
      orl_ff  <= orl_in;
      opd_ff  <= opd_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_qx        = ox_ff;
   assign rsp_qy        = oy_ff;
   assign rsp_qz        = oz_ff;
   assign rsp_run_last  = orl_ff;
   assign rsp_poly_done = opd_ff;

endmodule

// File: src/polygon_plane_clip.sv
// ----------------------------------------------------------------------------
// polygon_plane_clip
// One Sutherland-Hodgman clip stage of a polygon against a single plane.
// ----------------------------------------------------------------------------
// Usage: program normal_x/y/z and plane_offset (Q16.16) through the csr_
// port while idle; csr_ready is always high. Send a priming transaction
// (op = 0) with the closing vertex and vert_count, then every vertex
// (op = 1), final_vertex set on the last. Each vertex yields zero, one or
// two result transactions; run_last marks the last of a vertex, poly_done
// the last of the polygon.
// Front: each item passes the accept step, three products on one shared
// 32x32 multiplier, a sum and the classify step in turn, then the edge is
// queued in a two-entry queue; the next item is taken only after that.
// Back: an edge that keeps only the current vertex emits it directly; an edge
// with an intersection runs the 32-step restoring divider (skipped when the
// current vertex is on the plane) and a multiply and an add step per axis.
// Reset clears the previous vertex and distance to zero and the normal to
// +z. A stalled result holds in the output register; the back end then
// waits, the queue fills and the front end raises req_stall.
// ----------------------------------------------------------------------------
module polygon_plane_clip import ppc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [IDX_W-1:0]          csr_index,
   input  logic [COORD_W-1:0]        csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic signed [COORD_W-1:0] req_px,
   input  logic signed [COORD_W-1:0] req_py,
   input  logic signed [COORD_W-1:0] req_pz,
   input  logic [CNT_W-1:0]          req_vert_count,
   input  logic                      req_final_vertex,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_qx,
   output logic signed [COORD_W-1:0] rsp_qy,
   output logic signed [COORD_W-1:0] rsp_qz,
   output logic                      rsp_run_last,
   output logic                      rsp_poly_done
);

   cfg_type  cfg_ff, cfg_in;
   edge_type push_data, pop_data;
   logic     push, pop, fifo_full, fifo_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NORMAL_X:     cfg_in.nx     = csr_data;
            CSR_NORMAL_Y:     cfg_in.ny     = csr_data;
            CSR_NORMAL_Z:     cfg_in.nz     = csr_data;
            CSR_PLANE_OFFSET: cfg_in.offset = csr_data;
            default:          cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx     <= '0;
         cfg_ff.ny     <= '0;
         cfg_ff.nz     <= 32'sh0001_0000;
         cfg_ff.offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppc_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_pz           (req_pz),
      .req_vert_count   (req_vert_count),
      .req_final_vertex (req_final_vertex),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_data        (push_data)
   );

   ppc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   ppc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_empty),
      .fifo_data     (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_qx        (rsp_qx),
      .rsp_qy        (rsp_qy),
      .rsp_qz        (rsp_qz),
      .rsp_run_last  (rsp_run_last),
      .rsp_poly_done (rsp_poly_done)
   );

endmodule
